/* rtl/lrufl_pkg.sv */
// ----------------------------------------------------------------------------
// lrufl_pkg
// Types and codes shared by the free list manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrufl_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic [1:0] KIND_TAIL   = 2'd0;
  localparam logic [1:0] KIND_HEAD   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] buffer_index;
  } lrufl_cmd_t;

  typedef struct packed {
    logic             status;
    logic             list_empty;
    logic [IDX_W-1:0] first_buffer;
    logic [IDX_W-1:0] last_buffer;
  } lrufl_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UNLINK = 4'b0010,
    ST_LINK_A = 4'b0100,
    ST_LINK_B = 4'b1000
  } lrufl_state_t;

endpackage

`default_nettype wire

/* rtl/lru_free_list_manager_core.sv */
// ----------------------------------------------------------------------------
// lru_free_list_manager_core
// Circular doubly linked LRU free list over a pool of numbered buffers.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (cmd.kind, cmd.buffer_index) is taken at a clock
//   edge where start is high and busy is low. kind selects insert at tail,
//   insert at head (most recently used) or remove; an insert of a member
//   first unlinks it. Every command gives exactly one result transaction:
//   done is high for one cycle with result holding the status, the empty
//   flag and the first and last buffers of the list after the command.
//   Timing: the link memories are read in the accept cycle, the unlink is
//   written in ST_UNLINK, and an insert then writes the new links in
//   ST_LINK_A and ST_LINK_B, since each link memory has one write port. busy
//   is high in ST_UNLINK and, for an insert, in ST_LINK_A and ST_LINK_B;
//   done rises at the edge where busy falls, and no new command is taken before.
//   The sentinel's links live in registers, the buffer links in two RAMs.
//   Reset leaves the list empty and clears all membership flags; the link
//   RAMs are not cleared, no clearing pass is needed.
//   The receiver cannot stall: result is valid only in the done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_free_list_manager_core
  import lrufl_pkg::*;
#(
  parameter int unsigned BUFFERS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire lrufl_cmd_t cmd,
  output logic            done,
  output lrufl_rsp_t      result
);

  localparam int unsigned LW  = $clog2(BUFFERS + 1);
  localparam int unsigned MF  = (BUFFERS < 64) ? BUFFERS : 64;
  localparam int unsigned MIW = $clog2(MF);
  localparam logic [LW-1:0] SENT = LW'(BUFFERS);

  lrufl_state_t state, state_next;

  logic [1:0]       kind_q;
  logic [IDX_W-1:0] buf_q;
  logic             in_pool_q;
  logic             hit_q;

  logic [LW-1:0] head_next, head_next_next;
  logic [LW-1:0] head_prev, head_prev_next;
  logic [MF-1:0] member, member_next;

  logic       done_next;
  lrufl_rsp_t result_calc;

  logic          accept;
  logic          in_pool_c;
  logic [LW-1:0] rd_next, rd_prev;
  logic [LW-1:0] buf_addr;
  logic [MIW-1:0] buf_m;

  logic          nx_we, pv_we;
  logic [LW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign in_pool_c = ({26'd0, cmd.buffer_index} < 32'(BUFFERS));
  assign buf_addr  = LW'(buf_q);
  assign buf_m     = buf_q[MIW-1:0];

  lrufl_ram #(.WIDTH(LW), .DEPTH(BUFFERS + 1)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (accept),
    .raddr (LW'(cmd.buffer_index)),
    .rdata (rd_next)
  );

  lrufl_ram #(.WIDTH(LW), .DEPTH(BUFFERS + 1)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (accept),
    .raddr (LW'(cmd.buffer_index)),
    .rdata (rd_prev)
  );

  always_comb begin
    state_next     = state;
    head_next_next = head_next;
    head_prev_next = head_prev;
    member_next    = member;
    done_next      = 1'b0;
    nx_we          = 1'b0;
    nx_waddr       = '0;
    nx_wdata       = '0;
    pv_we          = 1'b0;
    pv_waddr       = '0;
    pv_wdata       = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        // link data of the buffer arrived from the read in the accept cycle
        if (hit_q) begin
          if (rd_prev == SENT) begin
            head_next_next = rd_next;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = rd_prev;
            nx_wdata = rd_next;
          end
          if (rd_next == SENT) begin
            head_prev_next = rd_prev;
          end else begin
            pv_we    = 1'b1;
            pv_waddr = rd_next;
            pv_wdata = rd_prev;
          end
          member_next[buf_m] = 1'b0;
        end
        if (in_pool_q && (kind_q == KIND_TAIL || kind_q == KIND_HEAD)) begin
          state_next = ST_LINK_A;
        end else begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      ST_LINK_A: begin
        nx_we    = 1'b1;
        nx_waddr = buf_addr;
        pv_we    = 1'b1;
        pv_waddr = buf_addr;
        if (kind_q == KIND_TAIL) begin
          nx_wdata = SENT;
          pv_wdata = head_prev;
        end else begin
          nx_wdata = head_next;
          pv_wdata = SENT;
        end
        state_next = ST_LINK_B;
      end
      ST_LINK_B: begin
        if (kind_q == KIND_TAIL) begin
          if (head_prev == SENT) begin
            head_next_next = buf_addr;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = head_prev;
            nx_wdata = buf_addr;
          end
          head_prev_next = buf_addr;
        end else begin
          if (head_next == SENT) begin
            head_prev_next = buf_addr;
          end else begin
            pv_we    = 1'b1;
            pv_waddr = head_next;
            pv_wdata = buf_addr;
          end
          head_next_next = buf_addr;
        end
        member_next[buf_m] = 1'b1;
        state_next = ST_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result_calc.status       = (kind_q == KIND_REMOVE && !hit_q) ? STATUS_ABSENT
                                                                 : STATUS_DONE;
    result_calc.list_empty   = (head_next_next == SENT);
    result_calc.first_buffer = result_calc.list_empty ? '0 : IDX_W'(head_next_next);
    result_calc.last_buffer  = result_calc.list_empty ? '0 : IDX_W'(head_prev_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_next <= SENT;
      head_prev <= SENT;
      member    <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      head_next <= head_next_next;
      head_prev <= head_prev_next;
      member    <= member_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= cmd.kind;
      buf_q     <= cmd.buffer_index;
      in_pool_q <= in_pool_c;
      // the unused kind never unlinks anything
      hit_q     <= in_pool_c && member[cmd.buffer_index[MIW-1:0]] &&
                   (cmd.kind == KIND_TAIL || cmd.kind == KIND_HEAD ||
                    cmd.kind == KIND_REMOVE);
    end
    if (done_next) begin
      result <= result_calc;
    end
  end

`ifndef SYNTH
  a_head_tail_agree: assert property (@(posedge clk) disable iff (rst)
    (head_next == SENT) == (head_prev == SENT))
    else $error("head and tail links disagree on empty list");

  a_members_vs_empty: assert property (@(posedge clk) disable iff (rst)
    ($countones(member) == 0) == (head_next == SENT))
    else $error("membership flags disagree with list links");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result for a transaction");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");
`endif

endmodule

`default_nettype wire

/* rtl/lrufl_ram.sv */
// ----------------------------------------------------------------------------
// lrufl_ram
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrufl_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 65
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* dv/lru_free_list_manager_core_test.sv */
// ----------------------------------------------------------------------------
// lru_free_list_manager_core_test
// Drives insert, remove and unused commands into the free list manager and
// checks each result against a directed row's view or a local model of the
// list: a table of corner cases first, then random traffic in fill, mixed,
// drain and narrow-index phases, with random command-side idle cycles outside a quiet run.
// ----------------------------------------------------------------------------
module lru_free_list_manager_core_test
  import lrufl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUFFERS    = 64;
  localparam logic [6:0]  SENTINEL   = 7'(BUFFERS);
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          RAND_ITEMS = 1150;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct packed {
    lrufl_cmd_t c;
    logic       chk;
    lrufl_rsp_t r;
  } cmd_row_t;

  localparam int DIR_ROWS = 21;
  // the list contents after each row are noted at the end of the line
  localparam cmd_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{KIND_REMOVE, 6'd0},  1'b1, '{STATUS_ABSENT, 1'b1, 6'd0,  6'd0}},  // empty
    '{'{KIND_UNUSED, 6'd63}, 1'b1, '{STATUS_DONE,   1'b1, 6'd0,  6'd0}},  // empty
    '{'{KIND_TAIL,   6'd0},  1'b1, '{STATUS_DONE,   1'b0, 6'd0,  6'd0}},  // 0
    '{'{KIND_TAIL,   6'd63}, 1'b1, '{STATUS_DONE,   1'b0, 6'd0,  6'd63}}, // 0 63
    '{'{KIND_HEAD,   6'd63}, 1'b1, '{STATUS_DONE,   1'b0, 6'd63, 6'd0}},  // 63 0
    '{'{KIND_HEAD,   6'd63}, 1'b1, '{STATUS_DONE,   1'b0, 6'd63, 6'd0}},  // 63 0
    '{'{KIND_TAIL,   6'd0},  1'b1, '{STATUS_DONE,   1'b0, 6'd63, 6'd0}},  // 63 0
    '{'{KIND_UNUSED, 6'd21}, 1'b1, '{STATUS_DONE,   1'b0, 6'd63, 6'd0}},  // 63 0
    '{'{KIND_REMOVE, 6'd42}, 1'b1, '{STATUS_ABSENT, 1'b0, 6'd63, 6'd0}},  // 63 0
    '{'{KIND_HEAD,   6'd21}, 1'b0, '0},                                   // 21 63 0
    '{'{KIND_TAIL,   6'd42}, 1'b0, '0},                                   // 21 63 0 42
    '{'{KIND_REMOVE, 6'd63}, 1'b0, '0},                                   // 21 0 42
    '{'{KIND_TAIL,   6'd21}, 1'b0, '0},                                   // 0 42 21
    '{'{KIND_HEAD,   6'd42}, 1'b0, '0},                                   // 42 0 21
    '{'{KIND_REMOVE, 6'd42}, 1'b0, '0},                                   // 0 21
    '{'{KIND_REMOVE, 6'd21}, 1'b0, '0},                                   // 0
    '{'{KIND_REMOVE, 6'd0},  1'b1, '{STATUS_DONE,   1'b1, 6'd0,  6'd0}},  // empty
    '{'{KIND_REMOVE, 6'd0},  1'b1, '{STATUS_ABSENT, 1'b1, 6'd0,  6'd0}},  // empty
    '{'{KIND_HEAD,   6'd42}, 1'b0, '0},                                   // 42
    '{'{KIND_UNUSED, 6'd0},  1'b0, '0},                                   // 42
    '{'{KIND_REMOVE, 6'd42}, 1'b0, '0}                                    // empty
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  lrufl_cmd_t cmd = '0;
  logic       busy;
  logic       done;
  lrufl_rsp_t result;

  // typed expectation that travels with the command currently offered
  logic       row_chk = 1'b0;
  lrufl_rsp_t row_rsp = '0;

  // local copy of the list
  logic [6:0] fwd_link  [BUFFERS+1];
  logic [6:0] back_link [BUFFERS+1];
  logic       on_list   [BUFFERS];

  // membership as seen from the command stream, used to aim removes
  logic       sent_member [BUFFERS];

  lrufl_rsp_t expected_views [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;

  lru_free_list_manager_core #(.BUFFERS(BUFFERS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lru_free_list_manager_core");
      $finish;
    end
  end

  function automatic void unlink_entry(logic [6:0] b);
    logic [6:0] p;
    logic [6:0] n;
    p = back_link[b];
    n = fwd_link[b];
    fwd_link[p]  = n;
    back_link[n] = p;
    fwd_link[b]  = '0;
    back_link[b] = '0;
    on_list[b]   = 1'b0;
  endfunction

  // applies one command to the local list and returns the view after it
  function automatic lrufl_rsp_t apply_list_op(lrufl_cmd_t c);
    lrufl_rsp_t v;
    logic [6:0] b;
    logic [6:0] at;
    logic [6:0] n;
    b = {1'b0, c.buffer_index};
    v = '0;
    v.status = STATUS_DONE;
    case (c.kind)
      KIND_TAIL, KIND_HEAD: begin
        if (on_list[b]) unlink_entry(b);
        at = (c.kind == KIND_TAIL) ? back_link[SENTINEL] : SENTINEL;
        n = fwd_link[at];
        fwd_link[b]  = n;
        back_link[b] = at;
        back_link[n] = b;
        fwd_link[at] = b;
        on_list[b]   = 1'b1;
      end
      KIND_REMOVE: begin
        if (on_list[b]) unlink_entry(b);
        else v.status = STATUS_ABSENT;
      end
      default: ;
    endcase
    v.list_empty = (fwd_link[SENTINEL] == SENTINEL);
    if (!v.list_empty) begin
      v.first_buffer = fwd_link[SENTINEL][5:0];
      v.last_buffer  = back_link[SENTINEL][5:0];
    end
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    lrufl_rsp_t want;
    lrufl_rsp_t model_view;
    if (!rst) begin
      if (done) begin
        if (expected_views.size() == 0) begin
          $error("result transaction with nothing expected: %p", result);
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatch_count++;
          end
          if (result.list_empty !== want.list_empty) begin
            $error("list_empty: expected %0d, got %0d", want.list_empty,
                   result.list_empty);
            mismatch_count++;
          end
          if (result.first_buffer !== want.first_buffer) begin
            $error("first_buffer: expected %0d, got %0d", want.first_buffer,
                   result.first_buffer);
            mismatch_count++;
          end
          if (result.last_buffer !== want.last_buffer) begin
            $error("last_buffer: expected %0d, got %0d", want.last_buffer,
                   result.last_buffer);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        model_view = apply_list_op(cmd);
        expected_views.push_back(row_chk ? row_rsp : model_view);
      end
    end
  end

  // offers one command, optionally after random idle cycles, and returns at
  // the edge where it is taken
  task automatic send_cmd(lrufl_cmd_t c, logic chk, lrufl_rsp_t r, bit may_idle);
    int gap;
    gap = 0;
    if (may_idle) begin
      while ($urandom_range(99) < 27) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    row_chk <= chk;
    row_rsp <= r;
    if (c.kind == KIND_TAIL || c.kind == KIND_HEAD) sent_member[c.buffer_index] = 1'b1;
    else if (c.kind == KIND_REMOVE) sent_member[c.buffer_index] = 1'b0;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    lrufl_cmd_t c;
    int         phase;
    int         pick;
    int         t_tail;
    int         t_head;
    int         t_rem;
    int         idx;
    bit         quiet;
    for (int i = 0; i < BUFFERS; i++) begin
      on_list[i]     = 1'b0;
      sent_member[i] = 1'b0;
    end
    for (int i = 0; i <= BUFFERS; i++) begin
      fwd_link[i]  = '0;
      back_link[i] = '0;
    end
    fwd_link[SENTINEL]  = SENTINEL;
    back_link[SENTINEL] = SENTINEL;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_cmd(DIR_TABLE[i].c, DIR_TABLE[i].chk, DIR_TABLE[i].r, 1'b1);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      phase = (n / 128) % 4;
      quiet = (n >= 512 && n < 768);
      // fill, mixed, drain, then a narrow set of indexes with heavy reuse
      case (phase)
        0:       begin t_tail = 45; t_head = 85; t_rem = 95; end
        1:       begin t_tail = 30; t_head = 60; t_rem = 95; end
        2:       begin t_tail = 15; t_head = 30; t_rem = 95; end
        default: begin t_tail = 30; t_head = 60; t_rem = 94; end
      endcase
      pick = $urandom_range(99);
      if (pick < t_tail)      c.kind = KIND_TAIL;
      else if (pick < t_head) c.kind = KIND_HEAD;
      else if (pick < t_rem)  c.kind = KIND_REMOVE;
      else                    c.kind = KIND_UNUSED;

      if (phase == 3) c.buffer_index = {($urandom_range(1) ? 3'b111 : 3'b000),
                                        3'($urandom_range(7))};
      else            c.buffer_index = 6'($urandom_range(63));

      // most removes aim at a current member
      if (c.kind == KIND_REMOVE && $urandom_range(3) != 0) begin
        idx = c.buffer_index;
        for (int k = 0; k < BUFFERS; k++) begin
          if (!sent_member[idx]) idx = (idx + 1) % BUFFERS;
        end
        c.buffer_index = 6'(idx);
      end
      send_cmd(c, 1'b0, '0, !quiet);
    end
    start <= 1'b0;

    while (expected_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("PASS lru_free_list_manager_core");
    end else begin
      $display("FAIL lru_free_list_manager_core");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lrufl_pkg.sv
rtl/lrufl_ram.sv
rtl/lru_free_list_manager_core.sv
dv/lru_free_list_manager_core_test.sv
